FILE: hdl/dn2d_pkg.sv
// dn2d_pkg: types, constants and small decode functions for the day number to date block.
// No dependencies; used by dn2d_ctrl, dn2d_dpath and day_number_to_date.
package dn2d_pkg;

	localparam int unsigned DAY_W   = 22;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MON_W   = 4;
	localparam int unsigned DOM_W   = 5;
	localparam int unsigned SHIFT_W = 3;

	localparam logic [DAY_W-1:0] DAYS_400Y = 22'd146097;
	localparam logic [DAY_W-1:0] DAYS_100Y = 22'd36524;
	localparam logic [DAY_W-1:0] DAYS_4Y   = 22'd1461;
	localparam logic [DAY_W-1:0] DAYS_1Y   = 22'd365;

	localparam logic [SHIFT_W-1:0] DIV100_LAST = 3'd1;
	localparam logic [SHIFT_W-1:0] DIV4_LAST   = 3'd4;
	localparam logic [SHIFT_W-1:0] DIV1_LAST   = 3'd1;

	localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_D400,
		ST_D100,
		ST_D4,
		ST_D1,
		ST_MONTH,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_MONTH
	} op_t;

	typedef enum logic [1:0] {
		PH_400,
		PH_100,
		PH_4,
		PH_1
	} phase_t;

	typedef struct packed {
		op_t                op;
		phase_t             phase;
		logic [SHIFT_W-1:0] shift;
	} cmd_t;

	typedef struct packed {
		logic invalid;
		logic month_more;
	} status_t;

	function automatic logic [DAY_W-1:0] phase_days(input phase_t ph);
		logic [DAY_W-1:0] d;
		unique case (ph)
			PH_400: d = DAYS_400Y;
			PH_100: d = DAYS_100Y;
			PH_4:   d = DAYS_4Y;
			PH_1:   d = DAYS_1Y;
			default: d = DAYS_1Y;
		endcase
		return d;
	endfunction

	function automatic logic [YEAR_W-1:0] phase_years(input phase_t ph);
		logic [YEAR_W-1:0] y;
		unique case (ph)
			PH_400: y = 14'd400;
			PH_100: y = 14'd100;
			PH_4:   y = 14'd4;
			PH_1:   y = 14'd1;
			default: y = 14'd1;
		endcase
		return y;
	endfunction

	function automatic logic [DOM_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DOM_W-1:0] len;
		unique case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

FILE: hdl/dn2d_dpath.sv
// dn2d_dpath: remainder, year, month and quotient registers with the shared subtractor.
// Depends on dn2d_pkg; driven by dn2d_ctrl through cmd_t, reports through status_t.
module dn2d_dpath #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                          clk,
	input  logic [dn2d_pkg::DAY_W-1:0]    day_number,
	input  dn2d_pkg::cmd_t                cmd,
	output dn2d_pkg::status_t             status,
	output logic [dn2d_pkg::DOM_W-1:0]    day_of_month,
	output logic [dn2d_pkg::MON_W-1:0]    month,
	output logic [dn2d_pkg::YEAR_W-1:0]   year,
	output logic                          invalid
);

	localparam logic [dn2d_pkg::DAY_W-1:0] LAST_DAY = dn2d_pkg::DAY_W'(
		365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

	logic [dn2d_pkg::DAY_W-1:0]  r_q;
	logic [dn2d_pkg::YEAR_W-1:0] year_q;
	logic [dn2d_pkg::MON_W-1:0]  month_q;
	logic                        inv_q;
	logic [1:0]                  q100_q;
	logic [4:0]                  q4_q;
	logic [1:0]                  q1_q;

	logic [dn2d_pkg::DAY_W-1:0]  sub;
	logic [dn2d_pkg::YEAR_W-1:0] yrs;
	logic                        ge;
	logic                        leap;
	logic [dn2d_pkg::DOM_W-1:0]  mlen;

	// year = 400*q400 + 100*q100 + 4*q4 + q1 + 1
	assign leap = (q1_q == 2'd3) && ((q4_q != 5'd24) || (q100_q == 2'd3));
	assign mlen = dn2d_pkg::month_len(month_q, leap);
	assign sub  = dn2d_pkg::phase_days(cmd.phase) << cmd.shift;
	assign yrs  = dn2d_pkg::phase_years(cmd.phase) << cmd.shift;
	assign ge   = r_q >= sub;

	always_ff @(posedge clk) begin
		case (cmd.op)
			dn2d_pkg::OP_LOAD: begin
				r_q     <= day_number - dn2d_pkg::DAY_W'(1);
				inv_q   <= (day_number == '0) || (day_number > LAST_DAY);
				year_q  <= dn2d_pkg::YEAR_W'(1);
				month_q <= dn2d_pkg::MONTH_JAN;
				q100_q  <= '0;
				q4_q    <= '0;
				q1_q    <= '0;
			end
			dn2d_pkg::OP_DIV: begin
				if (ge) begin
					r_q    <= r_q - sub;
					year_q <= year_q + yrs;
				end
				case (cmd.phase)
					dn2d_pkg::PH_100: q100_q <= {q100_q[0], ge};
					dn2d_pkg::PH_4:   q4_q   <= {q4_q[3:0], ge};
					dn2d_pkg::PH_1:   q1_q   <= {q1_q[0], ge};
					default: ;
				endcase
			end
			dn2d_pkg::OP_MONTH: begin
				r_q     <= r_q - dn2d_pkg::DAY_W'(mlen);
				month_q <= month_q + dn2d_pkg::MON_W'(1);
			end
			default: ;
		endcase
	end

	assign status.invalid    = inv_q;
	assign status.month_more = (month_q < dn2d_pkg::MONTH_DEC) &&
		(r_q >= dn2d_pkg::DAY_W'(mlen));

	assign day_of_month = inv_q ? '0 : r_q[dn2d_pkg::DOM_W-1:0] + dn2d_pkg::DOM_W'(1);
	assign month        = inv_q ? '0 : month_q;
	assign year         = inv_q ? '0 : year_q;
	assign invalid      = inv_q;

endmodule

FILE: hdl/dn2d_ctrl.sv
// dn2d_ctrl: state machine sequencing load, block division steps and month stripping.
// Depends on dn2d_pkg; drives dn2d_dpath through cmd_t.
module dn2d_ctrl #(
	parameter int unsigned DIV400_STEPS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  dn2d_pkg::status_t status,
	output dn2d_pkg::cmd_t    cmd
);

	dn2d_pkg::state_t                 state_q, state_d;
	logic [dn2d_pkg::SHIFT_W-1:0]     step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dn2d_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		cmd.op    = dn2d_pkg::OP_NONE;
		cmd.phase = dn2d_pkg::PH_400;
		cmd.shift = step_q;
		unique case (state_q)
			dn2d_pkg::ST_IDLE: begin
				if (start) begin
					cmd.op  = dn2d_pkg::OP_LOAD;
					state_d = dn2d_pkg::ST_CHECK;
				end
			end
			dn2d_pkg::ST_CHECK: begin
				step_d  = dn2d_pkg::SHIFT_W'(DIV400_STEPS - 1);
				state_d = status.invalid ? dn2d_pkg::ST_DONE : dn2d_pkg::ST_D400;
			end
			dn2d_pkg::ST_D400: begin
				cmd.op    = dn2d_pkg::OP_DIV;
				cmd.phase = dn2d_pkg::PH_400;
				if (step_q == '0) begin
					step_d  = dn2d_pkg::DIV100_LAST;
					state_d = dn2d_pkg::ST_D100;
				end else begin
					step_d = step_q - dn2d_pkg::SHIFT_W'(1);
				end
			end
			dn2d_pkg::ST_D100: begin
				cmd.op    = dn2d_pkg::OP_DIV;
				cmd.phase = dn2d_pkg::PH_100;
				if (step_q == '0) begin
					step_d  = dn2d_pkg::DIV4_LAST;
					state_d = dn2d_pkg::ST_D4;
				end else begin
					step_d = step_q - dn2d_pkg::SHIFT_W'(1);
				end
			end
			dn2d_pkg::ST_D4: begin
				cmd.op    = dn2d_pkg::OP_DIV;
				cmd.phase = dn2d_pkg::PH_4;
				if (step_q == '0) begin
					step_d  = dn2d_pkg::DIV1_LAST;
					state_d = dn2d_pkg::ST_D1;
				end else begin
					step_d = step_q - dn2d_pkg::SHIFT_W'(1);
				end
			end
			dn2d_pkg::ST_D1: begin
				cmd.op    = dn2d_pkg::OP_DIV;
				cmd.phase = dn2d_pkg::PH_1;
				if (step_q == '0) begin
					state_d = dn2d_pkg::ST_MONTH;
				end else begin
					step_d = step_q - dn2d_pkg::SHIFT_W'(1);
				end
			end
			dn2d_pkg::ST_MONTH: begin
				if (status.month_more) begin
					cmd.op = dn2d_pkg::OP_MONTH;
				end else begin
					state_d = dn2d_pkg::ST_DONE;
				end
			end
			dn2d_pkg::ST_DONE: begin
				state_d = dn2d_pkg::ST_IDLE;
			end
			default: begin
				state_d = dn2d_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != dn2d_pkg::ST_IDLE);
	assign done = (state_q == dn2d_pkg::ST_DONE);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not start work");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_month_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dn2d_pkg::ST_MONTH) && !status.month_more |=> done)
		else $error("month stripping ended without result");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == dn2d_pkg::OP_LOAD) |-> $past(done) || $past(!busy))
		else $error("load issued while a transaction was in flight");

endmodule

FILE: hdl/day_number_to_date.sv
// day_number_to_date: top level, day ordinal to proleptic Gregorian day, month, year.
// Depends on dn2d_pkg, dn2d_ctrl and dn2d_dpath.
//
// channel   signals                                   handshake
// -------   ---------------------------------------   -----------------------------
// input     day_number                                start high while busy low
// result    day_of_month, month, year, invalid        done high for one cycle
//
// A transaction runs from the accepting edge to done through the check state, then
// ceil(log2(MAX_YEAR/400+1)) + 9 block division steps on the shared subtractor (14 at the
// default), then the month state, which strips whole months, then the done state.
// An invalid ordinal goes from check straight to done. busy is low again the cycle after
// done. Reset returns the controller to idle; the receiver cannot stall.
module day_number_to_date #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [dn2d_pkg::DAY_W-1:0]  day_number,
	output logic                        done,
	output logic [dn2d_pkg::DOM_W-1:0]  day_of_month,
	output logic [dn2d_pkg::MON_W-1:0]  month,
	output logic [dn2d_pkg::YEAR_W-1:0] year,
	output logic                        invalid
);

	localparam int unsigned DIV400_STEPS =
		(MAX_YEAR / 400 < 1) ? 1 : $clog2(MAX_YEAR / 400 + 1);

	dn2d_pkg::cmd_t    cmd;
	dn2d_pkg::status_t status;

	dn2d_ctrl #(
		.DIV400_STEPS(DIV400_STEPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd)
	);

	dn2d_dpath #(
		.MAX_YEAR(MAX_YEAR)
	) u_dpath (
		.clk          (clk),
		.day_number   (day_number),
		.cmd          (cmd),
		.status       (status),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.invalid      (invalid)
	);

endmodule

FILE: test/date_checker.sv
// date_checker: watches the day number and date channels of day_number_to_date, predicts
// each date from the accepted day number and compares it field by field.
// Depends on dn2d_pkg for widths and the 400-, 100-, 4- and 1-year day counts.
module date_checker #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [dn2d_pkg::DAY_W-1:0]  day_number,
	input  logic                        done,
	input  logic [dn2d_pkg::DOM_W-1:0]  day_of_month,
	input  logic [dn2d_pkg::MON_W-1:0]  month,
	input  logic [dn2d_pkg::YEAR_W-1:0] year,
	input  logic                        invalid,
	output int                          fail_count,
	output int                          pending,
	output int                          dates_seen,
	output int                          invalid_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [dn2d_pkg::DOM_W-1:0]  dom;
		logic [dn2d_pkg::MON_W-1:0]  mon;
		logic [dn2d_pkg::YEAR_W-1:0] yr;
		logic                        inv;
	} cal_date_t;

	cal_date_t due_dates[$];

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic cal_date_t calendar_date(input logic [dn2d_pkg::DAY_W-1:0] n);
		int unsigned r, q400, q100, q4, q1, y, m, last;
		cal_date_t d;
		last = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
		d = '0;
		if (n == 0 || n > last) begin
			d.inv = 1'b1;
			return d;
		end
		r = n - 1;
		q400 = r / dn2d_pkg::DAYS_400Y;
		r = r % dn2d_pkg::DAYS_400Y;
		q100 = r / dn2d_pkg::DAYS_100Y;
		if (q100 > 3)
			q100 = 3;
		r -= q100 * dn2d_pkg::DAYS_100Y;
		q4 = r / dn2d_pkg::DAYS_4Y;
		r = r % dn2d_pkg::DAYS_4Y;
		q1 = r / dn2d_pkg::DAYS_1Y;
		if (q1 > 3)
			q1 = 3;
		r -= q1 * dn2d_pkg::DAYS_1Y;
		y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
		r += 1;
		m = 1;
		while (m < 12 && r > days_in_month(m, y)) begin
			r -= days_in_month(m, y);
			m++;
		end
		d.dom = r[dn2d_pkg::DOM_W-1:0];
		d.mon = m[dn2d_pkg::MON_W-1:0];
		d.yr  = y[dn2d_pkg::YEAR_W-1:0];
		return d;
	endfunction

	initial begin
		fail_count   = 0;
		dates_seen   = 0;
		invalid_seen = 0;
	end

	assign pending = due_dates.size();

	always @(posedge clk) begin
		cal_date_t exp_d;
		if (arst_n) begin
			// retire the result first: a new transaction never predates an older result
			if (done) begin
				dates_seen++;
				if (invalid)
					invalid_seen++;
				if (due_dates.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected date %0d/%0d/%0d invalid=%0b", $time,
						day_of_month, month, year, invalid);
				end else begin
					exp_d = due_dates.pop_front();
					if (day_of_month !== exp_d.dom) begin
						fail_count++;
						$display("%0t: day_of_month expected %0d actual %0d", $time,
							exp_d.dom, day_of_month);
					end
					if (month !== exp_d.mon) begin
						fail_count++;
						$display("%0t: month expected %0d actual %0d", $time,
							exp_d.mon, month);
					end
					if (year !== exp_d.yr) begin
						fail_count++;
						$display("%0t: year expected %0d actual %0d", $time,
							exp_d.yr, year);
					end
					if (invalid !== exp_d.inv) begin
						fail_count++;
						$display("%0t: invalid expected %0b actual %0b", $time,
							exp_d.inv, invalid);
					end
				end
			end
			if (start && !busy)
				due_dates.push_back(calendar_date(day_number));
		end
	end

endmodule

FILE: test/testbench.sv
// testbench: top level for day_number_to_date; drives directed and random day numbers
// under several idle patterns and gives the verdict. Depends on dn2d_pkg, the block
// and date_checker, which does all prediction and comparison.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_YEAR    = 9999;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          PHASE_ITEMS = 345;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [dn2d_pkg::DAY_W-1:0]  day_number;
	logic                        done;
	logic [dn2d_pkg::DOM_W-1:0]  day_of_month;
	logic [dn2d_pkg::MON_W-1:0]  month;
	logic [dn2d_pkg::YEAR_W-1:0] year;
	logic                        invalid;

	int fail_count;
	int pending;
	int dates_seen;
	int invalid_seen;
	int cycles;
	int sent;

	day_number_to_date #(.MAX_YEAR(MAX_YEAR)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.day_number   (day_number),
		.done         (done),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.invalid      (invalid)
	);

	date_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.day_number   (day_number),
		.done         (done),
		.day_of_month (day_of_month),
		.month        (month),
		.year         (year),
		.invalid      (invalid),
		.fail_count   (fail_count),
		.pending      (pending),
		.dates_seen   (dates_seen),
		.invalid_seen (invalid_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// last day of year y, counted from 1 January of year 1
	function automatic int unsigned year_end(input int unsigned y);
		return 365 * y + y / 4 - y / 100 + y / 400;
	endfunction

	function automatic logic [dn2d_pkg::DAY_W-1:0] random_day();
		int unsigned sel, y, c, last;
		last = year_end(MAX_YEAR);
		sel  = $urandom_range(99);
		y    = $urandom_range(MAX_YEAR, 1);
		c    = $urandom_range(MAX_YEAR / 100, 1);
		if (sel < 55)
			return dn2d_pkg::DAY_W'($urandom_range(last, 1));
		else if (sel < 72)
			return dn2d_pkg::DAY_W'(year_end(y) - 1 + $urandom_range(2));
		else if (sel < 85)
			return dn2d_pkg::DAY_W'(year_end(y - 1) + $urandom_range(62, 28));
		else if (sel < 92)
			return dn2d_pkg::DAY_W'(year_end(100 * c) - 1 + $urandom_range(2));
		else if (sel < 98)
			return dn2d_pkg::DAY_W'($urandom_range(2 ** dn2d_pkg::DAY_W - 1, last + 1));
		else
			return '0;
	endfunction

	task automatic send_day(input logic [dn2d_pkg::DAY_W-1:0] d, input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(40, 1)) @(posedge clk);
		end
		start      <= 1'b1;
		day_number <= d;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	initial begin
		int unsigned last;
		int          idle_pct[4];
		int unsigned directed[$];
		last = year_end(MAX_YEAR);
		idle_pct = '{0, 59, 25, 0};
		sent = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		day_number = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, first days, leap and century edges, last day of a 400-year cycle,
		// last valid day and beyond, all-ones and alternating bits
		directed = '{0, 1, 59, 60, 365, 366,
			year_end(3) + 60, year_end(4), year_end(99) + 60, year_end(100),
			year_end(399) + 60, year_end(400), year_end(400) + 1,
			year_end(1899) + 60, year_end(1999) + 60, year_end(2000),
			year_end(MAX_YEAR - 1) + 1, last, last + 1,
			32'h3FFFFF, 32'h2AAAAA, 32'h155555};
		foreach (directed[i])
			send_day(dn2d_pkg::DAY_W'(directed[i]), 0);

		foreach (idle_pct[p])
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_day(random_day(), idle_pct[p]);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d day numbers sent, %0d dates returned, %0d flagged invalid",
			sent, dates_seen, invalid_seen);
		$display("idle patterns: none, 59%% and 25%% sender gaps; %0d mismatches",
			fail_count);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
